@@ rtl/trapezoid_step_period_generator_macros.svh @@
// Assertion macros shared by the trapezoid step period generator RTL.
// Needs nothing else; files that check their logic include it by name.
`ifndef TRAPEZOID_STEP_PERIOD_GENERATOR_MACROS_SVH
`define TRAPEZOID_STEP_PERIOD_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPG_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tspg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSPG_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tspg: next-cycle check failed");

`endif

@@ rtl/tspg_pkg.sv @@
// Shared types and constants of the trapezoid step period generator.
// No dependencies; every other RTL file but the macros header imports it.
package tspg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RATE_W     = 16;
  localparam int CNT_W      = 32;
  localparam int PERIOD_W   = 16;
  localparam int LOOPS_W    = 3;
  localparam int DIVISOR_W  = 14;
  localparam int QUOT_W     = 21;
  localparam int DIV_CNT_W  = 5;

  localparam logic [RATE_W-1:0]   MAX_RATE   = 16'd40000;
  localparam logic [RATE_W-1:0]   RATE_HI    = 16'd20000;
  localparam logic [RATE_W-1:0]   RATE_MID   = 16'd10000;
  localparam logic [RATE_W-1:0]   MASK_QUART = 16'h3fff;
  localparam logic [RATE_W-1:0]   MASK_HALF  = 16'h7fff;
  localparam logic [QUOT_W-1:0]   TICK_FREQ  = 21'd2000000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd100;
  localparam logic [LOOPS_W-1:0]  GRAN_TICKS = 3'd6;

  localparam logic [LOOPS_W-1:0] LOOPS_ONE  = 3'd1;
  localparam logic [LOOPS_W-1:0] LOOPS_TWO  = 3'd2;
  localparam logic [LOOPS_W-1:0] LOOPS_FOUR = 3'd4;

  localparam logic REQ_START = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOMINAL  = 3'd0,
    CFG_INITIAL  = 3'd1,
    CFG_FINAL    = 3'd2,
    CFG_ACC_UNTL = 3'd3,
    CFG_DEC_AFTR = 3'd4,
    CFG_ACC_RATE = 3'd5,
    CFG_GRAN     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/tspg_if.sv @@
// Valid/ready channel interfaces for the step request and period response words.
// Depends on tspg_pkg for field widths.
interface tspg_in_if;
  import tspg_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [CNT_W-1:0] steps_done;

  modport source (output valid, req_type, steps_done, input ready);
  modport sink   (input valid, req_type, steps_done, output ready);
endinterface

interface tspg_out_if;
  import tspg_pkg::*;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] timer_period;
  logic [LOOPS_W-1:0]  loops_per_tick;

  modport source (output valid, timer_period, loops_per_tick, input ready);
  modport sink   (input valid, timer_period, loops_per_tick, output ready);
endinterface

@@ rtl/tspg_div.sv @@
// Bit-serial restoring divider: tick frequency divided by a step rate.
// Depends on tspg_pkg; one quotient bit per cycle.
module tspg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tspg_pkg::div_req_t req_i,
  output tspg_pkg::div_rsp_t rsp_o
);
  import tspg_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] divisor_q, divisor_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign trial = {rem_q, TICK_FREQ[cnt_q]};
  assign fits  = trial >= {1'b0, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = DIV_CNT_W'(QUOT_W - 1);
      divisor_d = req_i.divisor;
      rem_d     = '0;
      quot_d    = '0;
    end else if (busy_q) begin
      rem_d  = fits ? DIVISOR_W'(trial - {1'b0, divisor_q}) : trial[DIVISOR_W-1:0];
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ rtl/tspg_ramp.sv @@
// Registered ramp term: (ticks * acceleration rate) >> 24, kept to 16 bits.
// Depends on tspg_pkg for widths.
module tspg_ramp (
  input  logic                         clk_i,
  input  logic [tspg_pkg::CNT_W-1:0]   ticks_i,
  input  logic [tspg_pkg::CNT_W-1:0]   rate_i,
  output logic [tspg_pkg::RATE_W-1:0]  term_o
);
  import tspg_pkg::*;

  logic [2*CNT_W-1:0]  prod;
  logic [RATE_W-1:0]   term_q;

  assign prod = {{CNT_W{1'b0}}, ticks_i} * {{CNT_W{1'b0}}, rate_i};

  // The 2^24 scale drops the low bits; only sixteen bits above it are kept.
  always_ff @(posedge clk_i) begin
    term_q <= prod[24 +: RATE_W];
  end

  assign term_o = term_q;

endmodule

@@ rtl/trapezoid_step_period_generator.sv @@
// Trapezoid step period generator, top level with sequencer and ramp state.
// Sequence for an acceleration or deceleration step: multiply, rate, divider
// start, divider wait, finish, output; a start runs two divider passes, and a
// cruise step goes straight to output; a zero rate skips the divider.
// One word at a time: a new word is taken only once the result word is accepted.
// Reset (async, active low) clears configuration, ramp state and the sequencer.
`include "trapezoid_step_period_generator_macros.svh"

module trapezoid_step_period_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tspg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tspg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tspg_in_if.sink                           req_i,
  tspg_out_if.source                        rsp_o
);
  import tspg_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_RATE = 7'b0000100,
    S_DIVS = 7'b0001000,
    S_DIVW = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  // Which branch of the ramp the current word follows.
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_DECEL  = 2'd2,
    PH_CRUISE = 2'd3
  } phase_e;

  // Configuration registers.
  logic [RATE_W-1:0] nominal_q, initial_q, final_q;
  logic [CNT_W-1:0]  acc_until_q, dec_after_q, acc_rate_q;
  logic              gran_q;

  // Ramp state carried from word to word.
  logic [CNT_W-1:0]    accel_elapsed_q, decel_elapsed_q;
  logic [RATE_W-1:0]   accel_rate_now_q;
  logic [PERIOD_W-1:0] cruise_period_q;
  logic [LOOPS_W-1:0]  cruise_loops_q;

  // Sequencer and working registers.
  state_e              state_q;
  phase_e              phase_q;
  logic                first_q;
  logic [RATE_W-1:0]   rate_q;
  logic [LOOPS_W-1:0]  loops_q;
  logic                zero_q;
  logic [PERIOD_W-1:0] out_period_q;
  logic [LOOPS_W-1:0]  out_loops_q;

  // Combinational helpers.
  logic [RATE_W-1:0]    ramp_term;
  logic [CNT_W-1:0]     ramp_ticks;
  logic                 accept;
  logic [RATE_W:0]      acc_sum;
  logic [RATE_W-1:0]    acc_sat;
  logic [RATE_W-1:0]    acc_rate_new;
  logic [RATE_W-1:0]    dec_diff;
  logic [RATE_W-1:0]    dec_rate_new;
  logic [RATE_W-1:0]    capped;
  logic [RATE_W-1:0]    scaled;
  logic [LOOPS_W-1:0]   scaled_loops;
  logic [QUOT_W:0]      period_ext;
  logic [PERIOD_W-1:0]  period;
  logic                 rsp_ramp_word;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign accept = req_i.valid && req_i.ready;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q   <= '0;
      initial_q   <= '0;
      final_q     <= '0;
      acc_until_q <= '0;
      dec_after_q <= '0;
      acc_rate_q  <= '0;
      gran_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NOMINAL:  nominal_q   <= cfg_data_i[RATE_W-1:0];
        CFG_INITIAL:  initial_q   <= cfg_data_i[RATE_W-1:0];
        CFG_FINAL:    final_q     <= cfg_data_i[RATE_W-1:0];
        CFG_ACC_UNTL: acc_until_q <= cfg_data_i[CNT_W-1:0];
        CFG_DEC_AFTR: dec_after_q <= cfg_data_i[CNT_W-1:0];
        CFG_ACC_RATE: acc_rate_q  <= cfg_data_i[CNT_W-1:0];
        CFG_GRAN:     gran_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The ramp multiplier sees the elapsed-tick counter of the current phase.
  assign ramp_ticks = (phase_q == PH_DECEL) ? decel_elapsed_q : accel_elapsed_q;

  tspg_ramp u_ramp (
    .clk_i   (clk_i),
    .ticks_i (ramp_ticks),
    .rate_i  (acc_rate_q),
    .term_o  (ramp_term)
  );

  // Acceleration: initial rate plus ramp term, saturated to 16 bits, then
  // capped at the nominal rate.
  assign acc_sum      = {1'b0, ramp_term} + {1'b0, initial_q};
  assign acc_sat      = acc_sum[RATE_W] ? PERIOD_MAX : acc_sum[RATE_W-1:0];
  assign acc_rate_new = (acc_sat > nominal_q) ? nominal_q : acc_sat;

  // Deceleration: fall from the last acceleration rate, floored at the final
  // rate; a ramp term larger than the start point lands on the floor too.
  assign dec_diff     = accel_rate_now_q - ramp_term;
  assign dec_rate_new = (ramp_term <= accel_rate_now_q && dec_diff >= final_q) ?
                        dec_diff : final_q;

  // Rate scaling: cap, then fold fast rates into two or four steps per tick.
  always_comb begin
    capped = (rate_q > MAX_RATE) ? MAX_RATE : rate_q;
    if (capped > RATE_HI) begin
      scaled       = (capped >> 2) & MASK_QUART;
      scaled_loops = LOOPS_FOUR;
    end else if (capped > RATE_MID) begin
      scaled       = (capped >> 1) & MASK_HALF;
      scaled_loops = LOOPS_TWO;
    end else begin
      scaled       = capped;
      scaled_loops = LOOPS_ONE;
    end
  end

  assign div_req.start   = (state_q == S_DIVS) && (scaled != '0);
  assign div_req.divisor = scaled[DIVISOR_W-1:0];

  tspg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Period from the quotient: minus one, plus the granulator ticks when enabled, then
  // saturated at the 16-bit maximum and floored. A zero rate means maximum.
  always_comb begin
    period_ext = {1'b0, div_rsp.quot} - 1'b1;
    if (gran_q) begin
      period_ext = period_ext + (QUOT_W+1)'(loops_q) * (QUOT_W+1)'(GRAN_TICKS);
    end
    if (zero_q || period_ext > (QUOT_W+1)'(PERIOD_MAX)) begin
      period = PERIOD_MAX;
    end else if (period_ext < (QUOT_W+1)'(PERIOD_MIN)) begin
      period = PERIOD_MIN;
    end else begin
      period = period_ext[PERIOD_W-1:0];
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      phase_q          <= PH_START;
      first_q          <= 1'b0;
      accel_elapsed_q  <= '0;
      decel_elapsed_q  <= '0;
      accel_rate_now_q <= '0;
      cruise_period_q  <= '0;
      cruise_loops_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req_i.req_type == REQ_START) begin
              // A start word sizes the cruise period first, then the entry rate.
              phase_q <= PH_START;
              first_q <= 1'b1;
              state_q <= S_DIVS;
            end else if (req_i.steps_done <= acc_until_q) begin
              phase_q <= PH_ACCEL;
              state_q <= S_MUL;
            end else if (req_i.steps_done > dec_after_q) begin
              phase_q <= PH_DECEL;
              state_q <= S_MUL;
            end else begin
              phase_q <= PH_CRUISE;
              state_q <= S_OUT;
            end
          end
        end
        S_MUL:  state_q <= S_RATE;
        S_RATE: state_q <= S_DIVS;
        S_DIVS: state_q <= (scaled == '0) ? S_FIN : S_DIVW;
        S_DIVW: begin
          if (div_rsp.done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          case (phase_q)
            PH_START: begin
              if (first_q) begin
                cruise_period_q <= period;
                cruise_loops_q  <= loops_q;
                first_q         <= 1'b0;
                state_q         <= S_DIVS;
              end else begin
                accel_rate_now_q <= initial_q;
                accel_elapsed_q  <= CNT_W'(period);
                decel_elapsed_q  <= '0;
                state_q          <= S_OUT;
              end
            end
            PH_ACCEL: begin
              accel_rate_now_q <= rate_q;
              accel_elapsed_q  <= accel_elapsed_q + CNT_W'(period);
              state_q          <= S_OUT;
            end
            PH_DECEL: begin
              decel_elapsed_q <= decel_elapsed_q + CNT_W'(period);
              state_q         <= S_OUT;
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_OUT: begin
          if (rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working rate, scaling result and the output word.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      rate_q       <= nominal_q;
      out_period_q <= cruise_period_q;
      out_loops_q  <= cruise_loops_q;
    end
    if (state_q == S_RATE) begin
      rate_q <= (phase_q == PH_DECEL) ? dec_rate_new : acc_rate_new;
    end
    if (state_q == S_DIVS) begin
      loops_q <= scaled_loops;
      zero_q  <= (scaled == '0);
    end
    if (state_q == S_FIN) begin
      if (phase_q == PH_START && first_q) begin
        rate_q <= initial_q;
      end else begin
        out_period_q <= period;
        out_loops_q  <= loops_q;
      end
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = (state_q == S_OUT);
  assign rsp_o.timer_period   = out_period_q;
  assign rsp_o.loops_per_tick = out_loops_q;

  // A result word that came from the period rule rather than an unset cruise.
  assign rsp_ramp_word = rsp_o.valid && (rsp_o.loops_per_tick != '0);

  // The block never takes a word while a result is still waiting.
  `TSPG_ASSERT_IMP(a_ready_excl, clk_i, rst_ni, req_i.ready, !rsp_o.valid)
  // An accepted word keeps the input closed on the following cycle.
  `TSPG_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, !req_i.ready)
  // Loop counts are one, two or four, or zero for cruise before any start.
  `TSPG_ASSERT_IMP(a_loops_code, clk_i, rst_ni, rsp_o.valid, $onehot0(rsp_o.loops_per_tick))
  // Any computed period respects the floor.
  `TSPG_ASSERT_IMP(a_period_floor, clk_i, rst_ni, rsp_ramp_word, rsp_o.timer_period >= PERIOD_MIN)
  // The divider only finishes while the sequencer waits for it.
  `TSPG_ASSERT_IMP(a_div_done, clk_i, rst_ni, div_rsp.done, state_q == S_DIVW)

endmodule
